// ----- rtl/rbsi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared constants and types for the ray versus box slab intersection unit.
// ----------------------------------------------------------------------------
package rbsi_pkg;

	localparam int COORD_W   = 32;
	localparam int FRAC_W    = 16;
	localparam int DIFF_W    = COORD_W + 1;            // corner minus origin
	localparam int QUO_W     = COORD_W + 1;            // quotient bits built by the divider
	localparam int HEAD_W    = DIFF_W + FRAC_W - QUO_W; // dividend bits above the quotient
	localparam int LOW_W     = DIFF_W - HEAD_W;         // magnitude bits below the head
	localparam int LANE_LAT  = QUO_W + 2;               // init stage, bit stages, saturation
	localparam int AXES      = 3;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;

	localparam logic signed [COORD_W-1:0] VAL_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] VAL_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef enum logic [2:0] {
		REG_MIN_X = 3'd0,
		REG_MIN_Y = 3'd1,
		REG_MIN_Z = 3'd2,
		REG_MAX_X = 3'd3,
		REG_MAX_Y = 3'd4,
		REG_MAX_Z = 3'd5
	} reg_idx_t;

endpackage

// ----- rtl/rbsi_div_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_div_lane
// Pipelined restoring divider, one quotient bit per stage, with saturation
// of the signed result to the coordinate range.
// ----------------------------------------------------------------------------
module rbsi_div_lane
	import rbsi_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [DIFF_W-1:0] diff_mag,
	input  logic [COORD_W-1:0] d_mag,
	input  logic              neg,
	output coord_t            quo
);

	logic [COORD_W-1:0] rem_s  [0:QUO_W];
	logic [QUO_W-1:0]   bits_s [0:QUO_W];
	logic [QUO_W-1:0]   q_s    [0:QUO_W];
	logic [COORD_W-1:0] d_s    [0:QUO_W];
	logic               neg_s  [0:QUO_W];
	logic               ovf_s  [0:QUO_W];
	coord_t             quo_s;

	logic [HEAD_W-1:0] head;
	assign head = diff_mag[DIFF_W-1 -: HEAD_W];

	// the quotient only matters below 2^QUO_W, anything above saturates
	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0]  <= {{(COORD_W-HEAD_W){1'b0}}, head} >= d_mag;
			rem_s[0]  <= {{(COORD_W-HEAD_W){1'b0}}, head};
			bits_s[0] <= {diff_mag[LOW_W-1:0], {FRAC_W{1'b0}}};
			q_s[0]    <= '0;
			d_s[0]    <= d_mag;
			neg_s[0]  <= neg;
		end
	end

	for (genvar j = 1; j <= QUO_W; j++) begin : g_bit
		logic [COORD_W:0] trial;
		logic             take;
		assign trial = {rem_s[j-1], bits_s[j-1][QUO_W-1]};
		assign take  = trial >= {1'b0, d_s[j-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= take ? COORD_W'(trial - {1'b0, d_s[j-1]}) : trial[COORD_W-1:0];
				bits_s[j] <= {bits_s[j-1][QUO_W-2:0], 1'b0};
				q_s[j]    <= {q_s[j-1][QUO_W-2:0], take};
				d_s[j]    <= d_s[j-1];
				neg_s[j]  <= neg_s[j-1];
				ovf_s[j]  <= ovf_s[j-1];
			end
		end
	end

	logic [QUO_W-1:0] qf;
	assign qf = q_s[QUO_W];

	always_ff @(posedge clk) begin
		if (en) begin
			if (!neg_s[QUO_W]) begin
				if (ovf_s[QUO_W] || qf[QUO_W-1:COORD_W-1] != '0) begin
					quo_s <= VAL_MAX;
				end else begin
					quo_s <= coord_t'(qf[COORD_W-1:0]);
				end
			end else begin
				if (ovf_s[QUO_W] || qf > {2'b01, {(COORD_W-1){1'b0}}}) begin
					quo_s <= VAL_MIN;
				end else begin
					quo_s <= coord_t'(-qf[COORD_W-1:0]);
				end
			end
		end
	end

	assign quo = quo_s;

endmodule

// ----- rtl/ray_box_slab_intersect_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_unit
// Ray versus axis-aligned box test by the slab method in signed Q16.16.
// ----------------------------------------------------------------------------
// a request passes stage 1 setup, the init stage and 33 quotient-bit stages
// of the six divider lanes, saturation, ordering, reduction and the output register
// throughput: one request per cycle; a stalled result freezes the whole pipe
// reset clears all valid bits and loads the empty box into the corner registers
module ray_box_slab_intersect_unit
	import rbsi_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  coord_t            origin_x,
	input  coord_t            origin_y,
	input  coord_t            origin_z,
	input  coord_t            dir_x,
	input  coord_t            dir_y,
	input  coord_t            dir_z,
	input  coord_t            t_lower_in,
	input  coord_t            t_upper_in,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              hit,
	output coord_t            t_enter,
	output coord_t            t_leave
);

	coord_t box_lo_q [AXES];
	coord_t box_hi_q [AXES];
	reg_idx_t widx;
	logic     wr_en;

	assign pready = 1'b1;
	assign widx   = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < AXES; a++) begin
				box_lo_q[a] <= VAL_MAX;
				box_hi_q[a] <= VAL_MIN;
			end
		end else if (wr_en) begin
			case (widx)
				REG_MIN_X: box_lo_q[0] <= coord_t'(pwdata);
				REG_MIN_Y: box_lo_q[1] <= coord_t'(pwdata);
				REG_MIN_Z: box_lo_q[2] <= coord_t'(pwdata);
				REG_MAX_X: box_hi_q[0] <= coord_t'(pwdata);
				REG_MAX_Y: box_hi_q[1] <= coord_t'(pwdata);
				REG_MAX_Z: box_hi_q[2] <= coord_t'(pwdata);
				default: ;
			endcase
		end
	end

	always_comb begin
		case (widx)
			REG_MIN_X: prdata = box_lo_q[0];
			REG_MIN_Y: prdata = box_lo_q[1];
			REG_MIN_Z: prdata = box_lo_q[2];
			REG_MAX_X: prdata = box_hi_q[0];
			REG_MAX_Y: prdata = box_hi_q[1];
			REG_MAX_Z: prdata = box_hi_q[2];
			default:   prdata = '0;
		endcase
	end

	// whole pipe moves unless a finished result is held
	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	coord_t org [AXES];
	coord_t dir [AXES];
	assign org = '{origin_x, origin_y, origin_z};
	assign dir = '{dir_x, dir_y, dir_z};

	// stage 1: differences, magnitudes, zero-direction slab test
	logic              v_s1;
	logic [DIFF_W-1:0] lo_mag_s1 [AXES];
	logic [DIFF_W-1:0] hi_mag_s1 [AXES];
	logic              lo_neg_s1 [AXES];
	logic              hi_neg_s1 [AXES];
	logic [COORD_W-1:0] d_mag_s1 [AXES];
	logic [AXES-1:0]   zero_s1;
	logic [AXES-1:0]   inside_s1;
	coord_t            tlo_s1, tup_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	for (genvar a = 0; a < AXES; a++) begin : g_prep
		logic signed [DIFF_W-1:0] dl, dh;
		logic                     ds;
		assign dl = DIFF_W'(box_lo_q[a]) - DIFF_W'(org[a]);
		assign dh = DIFF_W'(box_hi_q[a]) - DIFF_W'(org[a]);
		assign ds = dir[a][COORD_W-1];
		always_ff @(posedge clk) begin
			if (adv) begin
				lo_mag_s1[a] <= dl[DIFF_W-1] ? DIFF_W'(-dl) : dl;
				hi_mag_s1[a] <= dh[DIFF_W-1] ? DIFF_W'(-dh) : dh;
				lo_neg_s1[a] <= dl[DIFF_W-1] ^ ds;
				hi_neg_s1[a] <= dh[DIFF_W-1] ^ ds;
				d_mag_s1[a]  <= ds ? COORD_W'(-dir[a]) : dir[a];
				zero_s1[a]   <= dir[a] == '0;
				inside_s1[a] <= org[a] >= box_lo_q[a] && org[a] <= box_hi_q[a];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tlo_s1 <= t_lower_in;
			tup_s1 <= t_upper_in;
		end
	end

	coord_t t0 [AXES];
	coord_t t1 [AXES];

	for (genvar a = 0; a < AXES; a++) begin : g_lane
		rbsi_div_lane u_lo (
			.clk     (clk),
			.en      (adv),
			.diff_mag(lo_mag_s1[a]),
			.d_mag   (d_mag_s1[a]),
			.neg     (lo_neg_s1[a]),
			.quo     (t0[a])
		);
		rbsi_div_lane u_hi (
			.clk     (clk),
			.en      (adv),
			.diff_mag(hi_mag_s1[a]),
			.d_mag   (d_mag_s1[a]),
			.neg     (hi_neg_s1[a]),
			.quo     (t1[a])
		);
	end

	// side data delayed alongside the divider lanes
	logic            v_dl_s   [LANE_LAT];
	logic [AXES-1:0] zero_dl_s   [LANE_LAT];
	logic [AXES-1:0] inside_dl_s [LANE_LAT];
	coord_t          tlo_dl_s [LANE_LAT];
	coord_t          tup_dl_s [LANE_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LANE_LAT; k++) v_dl_s[k] <= 1'b0;
		end else if (adv) begin
			v_dl_s[0] <= v_s1;
			for (int k = 1; k < LANE_LAT; k++) v_dl_s[k] <= v_dl_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zero_dl_s[0]   <= zero_s1;
			inside_dl_s[0] <= inside_s1;
			tlo_dl_s[0]    <= tlo_s1;
			tup_dl_s[0]    <= tup_s1;
			for (int k = 1; k < LANE_LAT; k++) begin
				zero_dl_s[k]   <= zero_dl_s[k-1];
				inside_dl_s[k] <= inside_dl_s[k-1];
				tlo_dl_s[k]    <= tlo_dl_s[k-1];
				tup_dl_s[k]    <= tup_dl_s[k-1];
			end
		end
	end

	// order stage: near and far per axis
	logic   v_ord_s;
	coord_t near_ord_s [AXES];
	coord_t far_ord_s  [AXES];
	coord_t tlo_ord_s, tup_ord_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_ord_s <= 1'b0;
		end else if (adv) begin
			v_ord_s <= v_dl_s[LANE_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tlo_ord_s <= tlo_dl_s[LANE_LAT-1];
			tup_ord_s <= tup_dl_s[LANE_LAT-1];
			for (int a = 0; a < AXES; a++) begin
				if (zero_dl_s[LANE_LAT-1][a]) begin
					near_ord_s[a] <= inside_dl_s[LANE_LAT-1][a] ? VAL_MIN : VAL_MAX;
					far_ord_s[a]  <= inside_dl_s[LANE_LAT-1][a] ? VAL_MAX : VAL_MIN;
				end else if (t0[a] < t1[a]) begin
					near_ord_s[a] <= t0[a];
					far_ord_s[a]  <= t1[a];
				end else begin
					near_ord_s[a] <= t1[a];
					far_ord_s[a]  <= t0[a];
				end
			end
		end
	end

	// reduce stage: largest near and smallest far, starting from the t bounds
	logic   v_red_s;
	coord_t ent_red_s, lev_red_s;
	coord_t ent_c, lev_c;

	always_comb begin
		ent_c = tlo_ord_s;
		lev_c = tup_ord_s;
		for (int a = 0; a < AXES; a++) begin
			if (near_ord_s[a] > ent_c) ent_c = near_ord_s[a];
			if (far_ord_s[a] < lev_c) lev_c = far_ord_s[a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_red_s <= 1'b0;
		end else if (adv) begin
			v_red_s <= v_ord_s;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ent_red_s <= ent_c;
			lev_red_s <= lev_c;
		end
	end

	// output register
	logic   out_v_q;
	logic   hit_q;
	coord_t enter_q, leave_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= v_red_s;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q   <= lev_red_s > ent_red_s;
			enter_q <= ent_red_s;
			leave_q <= lev_red_s;
		end
	end

	assign out_valid = out_v_q;
	assign hit       = hit_q;
	assign t_enter   = enter_q;
	assign t_leave   = leave_q;

	// hit agrees with the reported interval
	a_hit_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hit == (t_leave > t_enter)))
		else $error("hit disagrees with interval");

	// an accepted request shows up in the first stage
	a_enter_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_s1)
		else $error("accepted request lost at entry");

	// a held result keeps the pipe frozen
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(v_red_s) && $stable(enter_q)))
		else $error("pipe moved while result held");

	// front of the pipe stalls only behind a held result
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall without held result");

endmodule
